>>> sv/utf8d_pkg.sv
// Shared types and constants for the UTF-8 code point decoder.
`timescale 1ns / 1ps
package utf8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned QCNT_W = 3;

  localparam logic [CP_W-1:0]  QMARK     = CP_W'(63);
  localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

  // Lead byte classes
  localparam logic [2:0] LB_ASCII   = 3'd0;
  localparam logic [2:0] LB_SEQ2    = 3'd1;
  localparam logic [2:0] LB_SEQ3    = 3'd2;
  localparam logic [2:0] LB_SEQ4    = 3'd3;
  localparam logic [2:0] LB_INVALID = 3'd4;

  // Results caused by one item: qmarks '?' results, then an optional decoded point.
  typedef struct packed {
    logic [QCNT_W-1:0] qmarks;
    logic              has_point;
    logic [CP_W-1:0]   point;
    logic [LEN_W-1:0]  len;
    logic              eot;
  } desc_t;

endpackage

>>> sv/utf8d_decode.sv
// Per-byte decode logic and the open-sequence state registers.
`timescale 1ns / 1ps
module utf8d_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          byte_i,
  input  logic                eot_i,
  input  logic                take_i,
  output utf8d_pkg::desc_t    desc_o,
  output logic                has_result_o
);

  logic [1:0]  exp_r, exp_nxt;
  logic [1:0]  taken_r, taken_nxt;
  logic [20:0] part_r, part_nxt;

  logic [2:0]  lead_class;
  logic        is_cont;
  logic [1:0]  taken_inc;
  logic [20:0] part_sh;
  utf8d_pkg::desc_t d;

  always_comb begin
    if (byte_i[7] == 1'b0) begin
      lead_class = utf8d_pkg::LB_ASCII;
    end else if (byte_i[7:5] == 3'b110) begin
      lead_class = utf8d_pkg::LB_SEQ2;
    end else if (byte_i[7:4] == 4'b1110) begin
      lead_class = utf8d_pkg::LB_SEQ3;
    end else if (byte_i[7:3] == 5'b11110) begin
      lead_class = utf8d_pkg::LB_SEQ4;
    end else begin
      lead_class = utf8d_pkg::LB_INVALID;
    end
  end

  assign is_cont   = (byte_i[7:6] == 2'b10);
  assign taken_inc = taken_r + 2'd1;
  assign part_sh   = {part_r[14:0], byte_i[5:0]};

  always_comb begin
    d         = '0;
    d.eot     = eot_i;
    exp_nxt   = exp_r;
    taken_nxt = taken_r;
    part_nxt  = part_r;

    if (exp_r != 2'd0 && is_cont) begin
      if (taken_inc >= exp_r) begin
        d.has_point = 1'b1;
        d.point     = part_sh;
        d.len       = {1'b0, exp_r} + utf8d_pkg::LEN_ONE;
        exp_nxt     = 2'd0;
        taken_nxt   = 2'd0;
        part_nxt    = '0;
      end else begin
        taken_nxt = taken_inc;
        part_nxt  = part_sh;
      end
    end else begin
      if (exp_r != 2'd0) begin
        // bad continuation: flush the open sequence first
        d.qmarks  = {1'b0, taken_r} + 3'd1;
        exp_nxt   = 2'd0;
        taken_nxt = 2'd0;
        part_nxt  = '0;
      end
      case (lead_class)
        utf8d_pkg::LB_ASCII: begin
          d.has_point = 1'b1;
          d.point     = {13'd0, byte_i};
          d.len       = utf8d_pkg::LEN_ONE;
        end
        utf8d_pkg::LB_SEQ2: begin
          exp_nxt   = 2'd1;
          taken_nxt = 2'd0;
          part_nxt  = {16'd0, byte_i[4:0]};
        end
        utf8d_pkg::LB_SEQ3: begin
          exp_nxt   = 2'd2;
          taken_nxt = 2'd0;
          part_nxt  = {17'd0, byte_i[3:0]};
        end
        utf8d_pkg::LB_SEQ4: begin
          exp_nxt   = 2'd3;
          taken_nxt = 2'd0;
          part_nxt  = {18'd0, byte_i[2:0]};
        end
        default: begin
          d.qmarks = d.qmarks + 3'd1;
        end
      endcase
    end

    if (eot_i && exp_nxt != 2'd0) begin
      d.qmarks  = d.qmarks + {1'b0, taken_nxt} + 3'd1;
      exp_nxt   = 2'd0;
      taken_nxt = 2'd0;
      part_nxt  = '0;
    end
  end

  assign desc_o       = d;
  assign has_result_o = d.has_point || (d.qmarks != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= 2'd0;
      taken_r <= 2'd0;
      part_r  <= '0;
    end else if (take_i) begin
      exp_r   <= exp_nxt;
      taken_r <= taken_nxt;
      part_r  <= part_nxt;
    end
  end

endmodule

>>> sv/utf8d_emit.sv
// Result register: plays out the results of one item, one per cycle while out_ready is high.
`timescale 1ns / 1ps
module utf8d_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  utf8d_pkg::desc_t    desc_i,
  output logic                free_o,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [20:0]         out_code_point,
  output logic [2:0]          out_byte_length,
  output logic                out_last_of_item,
  output logic                out_last_of_text
);

  logic [2:0]  qcnt_r, qcnt_nxt;
  logic        pt_r, pt_nxt;
  logic [20:0] point_r;
  logic [2:0]  len_r;
  logic        eot_r;
  logic        take;
  logic        final_one;

  assign out_valid        = (qcnt_r != 3'd0) || pt_r;
  assign final_one        = pt_r ? (qcnt_r == 3'd0) : (qcnt_r == 3'd1);
  assign take             = out_valid && out_ready;
  assign free_o           = !out_valid || (out_ready && final_one);

  assign out_code_point   = (qcnt_r != 3'd0) ? utf8d_pkg::QMARK : point_r;
  assign out_byte_length  = (qcnt_r != 3'd0) ? utf8d_pkg::LEN_ONE : len_r;
  assign out_last_of_item = final_one;
  assign out_last_of_text = final_one && eot_r;

  always_comb begin
    qcnt_nxt = qcnt_r;
    pt_nxt   = pt_r;
    if (take) begin
      if (qcnt_r != 3'd0) begin
        qcnt_nxt = qcnt_r - 3'd1;
      end else begin
        pt_nxt = 1'b0;
      end
    end
    if (load_i) begin
      qcnt_nxt = desc_i.qmarks;
      pt_nxt   = desc_i.has_point;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= 3'd0;
      pt_r   <= 1'b0;
    end else begin
      qcnt_r <= qcnt_nxt;
      pt_r   <= pt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      point_r <= desc_i.point;
      len_r   <= desc_i.len;
      eot_r   <= desc_i.eot;
    end
  end

endmodule

>>> sv/utf8_codepoint_decoder.sv
// Top level of the streaming UTF-8 code point decoder.
// Usage:
//   Input channel in_valid/in_ready carries one text byte per item, with
//   in_end_of_text set on the final byte of a text.
//   Output channel out_valid/out_ready carries one result per item taken:
//   code point, byte length, last_of_item and last_of_text flags.
//   A byte is held in the input register, and its results are then loaded
//   into the result register and shown from there.
//   Throughput is one byte per cycle while each byte yields at most one
//   result and out_ready is high; a byte that yields k results (up to 4)
//   holds the result register until all k are taken. Bytes that yield no
//   result (lead and inner continuation bytes) pass even while a result waits.
//   A stalled receiver holds the current result stable; a byte with results
//   then holds the input register and the decode state, and in_ready drops
//   while it waits.
//   Synchronous active-low reset closes any open sequence and empties both
//   the input and the result registers.
`timescale 1ns / 1ps
module utf8_codepoint_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic [2:0]  out_byte_length,
  output logic        out_last_of_item,
  output logic        out_last_of_text
);

  logic       a_valid_r;
  logic [7:0] a_byte_r;
  logic       a_eot_r;
  logic       a_take;
  logic       has_result;
  logic       emit_free;
  utf8d_pkg::desc_t desc;

  assign a_take   = a_valid_r && (!has_result || emit_free);
  assign in_ready = !a_valid_r || a_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte_r <= in_text_byte;
      a_eot_r  <= in_end_of_text;
    end
  end

  utf8d_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_i       (a_byte_r),
    .eot_i        (a_eot_r),
    .take_i       (a_take),
    .desc_o       (desc),
    .has_result_o (has_result)
  );

  utf8d_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load_i           (a_take && has_result),
    .desc_i           (desc),
    .free_o           (emit_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_byte_length  (out_byte_length),
    .out_last_of_item (out_last_of_item),
    .out_last_of_text (out_last_of_text)
  );

endmodule

>>> sim/utf8_codepoint_checker.sv
// Checker for the UTF-8 decoder: predicts code points from accepted bytes and compares results.
`timescale 1ns / 1ps
module utf8_codepoint_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [7:0]                   in_text_byte,
  input  logic                         in_end_of_text,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [utf8d_pkg::CP_W-1:0]   out_code_point,
  input  logic [utf8d_pkg::LEN_W-1:0]  out_byte_length,
  input  logic                         out_last_of_item,
  input  logic                         out_last_of_text,
  output int unsigned                  mismatch_count,
  output int unsigned                  pending_count
);

  typedef struct packed {
    logic [utf8d_pkg::CP_W-1:0]  point;
    logic [utf8d_pkg::LEN_W-1:0] len;
    logic                        item_end;
    logic                        text_end;
  } decoded_t;

  decoded_t expected_points[$];

  // partial code point
  logic [1:0]                 seq_need;
  logic [1:0]                 seq_got;
  logic [utf8d_pkg::CP_W-1:0] seq_bits;

  // results of the byte being decoded
  decoded_t step_res[4];
  int       step_n;

  function automatic logic [2:0] lead_class(input logic [7:0] b);
    if (!b[7]) return utf8d_pkg::LB_ASCII;
    if (b[7:5] == 3'b110) return utf8d_pkg::LB_SEQ2;
    if (b[7:4] == 4'b1110) return utf8d_pkg::LB_SEQ3;
    if (b[7:3] == 5'b11110) return utf8d_pkg::LB_SEQ4;
    return utf8d_pkg::LB_INVALID;
  endfunction

  // at most four results per byte; extras are dropped
  task automatic put_point(input logic [utf8d_pkg::CP_W-1:0] cp,
                           input logic [utf8d_pkg::LEN_W-1:0] len);
    if (step_n < 4) begin
      step_res[step_n].point    = cp;
      step_res[step_n].len      = len;
      step_res[step_n].item_end = 1'b0;
      step_res[step_n].text_end = 1'b0;
      step_n++;
    end
  endtask

  task automatic close_seq();
    seq_need = '0;
    seq_got  = '0;
    seq_bits = '0;
  endtask

  // one '?' for the lead and one per continuation taken
  task automatic flush_seq();
    if (seq_need != 0) begin
      for (int k = 0; k <= seq_got; k++) put_point(utf8d_pkg::QMARK, utf8d_pkg::LEN_ONE);
    end
    close_seq();
  endtask

  task automatic take_lead(input logic [7:0] b);
    case (lead_class(b))
      utf8d_pkg::LB_ASCII: put_point(utf8d_pkg::CP_W'(b), utf8d_pkg::LEN_ONE);
      utf8d_pkg::LB_SEQ2: begin
        seq_need = 2'd1;
        seq_got  = '0;
        seq_bits = utf8d_pkg::CP_W'(b[4:0]);
      end
      utf8d_pkg::LB_SEQ3: begin
        seq_need = 2'd2;
        seq_got  = '0;
        seq_bits = utf8d_pkg::CP_W'(b[3:0]);
      end
      utf8d_pkg::LB_SEQ4: begin
        seq_need = 2'd3;
        seq_got  = '0;
        seq_bits = utf8d_pkg::CP_W'(b[2:0]);
      end
      default: put_point(utf8d_pkg::QMARK, utf8d_pkg::LEN_ONE);
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    step_n = 0;
    if (seq_need == 0) begin
      take_lead(b);
    end else if (b[7:6] == 2'b10) begin
      seq_bits = {seq_bits[utf8d_pkg::CP_W-7:0], b[5:0]};
      seq_got  = seq_got + 2'd1;
      if (seq_got >= seq_need) begin
        put_point(seq_bits, utf8d_pkg::LEN_W'(seq_need) + utf8d_pkg::LEN_ONE);
        close_seq();
      end
    end else begin
      flush_seq();
      take_lead(b);
    end
    if (eot) flush_seq();
    if (step_n > 0) begin
      step_res[step_n-1].item_end = 1'b1;
      step_res[step_n-1].text_end = eot;
    end
    for (int k = 0; k < step_n; k++) expected_points.insert(expected_points.size(), step_res[k]);
  endtask

  task automatic check_point();
    decoded_t want;
    if (expected_points.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result cp=%h len=%0d li=%b lt=%b", $realtime,
                 out_code_point, out_byte_length, out_last_of_item, out_last_of_text);
    end else begin
      want = expected_points.pop_front();
      if (want.point !== out_code_point || want.len !== out_byte_length ||
          want.item_end !== out_last_of_item || want.text_end !== out_last_of_text) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: mismatch exp cp=%h len=%0d li=%b lt=%b, got cp=%h len=%0d li=%b lt=%b",
                   $realtime, want.point, want.len, want.item_end, want.text_end,
                   out_code_point, out_byte_length, out_last_of_item, out_last_of_text);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      close_seq();
      expected_points.delete();
    end else begin
      if (in_valid && in_ready) decode_byte(in_text_byte, in_end_of_text);
      if (out_valid && out_ready) check_point();
    end
    pending_count = expected_points.size();
  end

endmodule

>>> sim/utf8_codepoint_decoder_test.sv
// Testbench top for the UTF-8 decoder: byte stimulus, receiver stalls, timeout and verdict.
`timescale 1ns / 1ps
module utf8_codepoint_decoder_test;

  localparam int RANDOM_BYTES = 175;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_item_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [7:0]                   in_text_byte = 8'h00;
  logic                         in_end_of_text = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [utf8d_pkg::CP_W-1:0]   out_code_point;
  logic [utf8d_pkg::LEN_W-1:0]  out_byte_length;
  logic                         out_last_of_item;
  logic                         out_last_of_text;

  int unsigned mismatch_count;
  int unsigned pending_count;

  text_item_t text_bytes[$];
  int         directed_count;
  int         cycles = 0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;

  always #5 clk = ~clk;

  utf8_codepoint_decoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_text_byte(in_text_byte),
    .in_end_of_text(in_end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_code_point(out_code_point),
    .out_byte_length(out_byte_length),
    .out_last_of_item(out_last_of_item),
    .out_last_of_text(out_last_of_text)
  );

  utf8_codepoint_checker checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_text_byte(in_text_byte),
    .in_end_of_text(in_end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_code_point(out_code_point),
    .out_byte_length(out_byte_length),
    .out_last_of_item(out_last_of_item),
    .out_last_of_text(out_last_of_text),
    .mismatch_count(mismatch_count),
    .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic eot);
    text_item_t t;
    t.b   = b;
    t.eot = eot;
    text_bytes.insert(text_bytes.size(), t);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // lead byte for a sequence of n bytes (2..4)
  function automatic logic [7:0] lead_byte(input int n);
    case (n)
      2: return 8'hC0 | 8'($urandom_range(0, 31));
      3: return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic build_directed();
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'hC2, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'hAC, 1'b0);
    add_byte(8'hF7, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'h80, 1'b0);  // stray continuation
    add_byte(8'hFF, 1'b0);  // invalid lead
    add_byte(8'hE2, 1'b0);  // broken 3-byte, then 'A'
    add_byte(8'h82, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'hF0, 1'b0);  // broken 4-byte by an invalid lead
    add_byte(8'h90, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hF8, 1'b0);
    add_byte(8'hF0, 1'b0);  // broken 4-byte, new lead left open at end of text
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hE0, 1'b1);
    add_byte(8'hC3, 1'b1);  // lone lead at end of text
  endtask

  task automatic build_random();
    int k;
    int n;
    while (text_bytes.size() < directed_count + RANDOM_BYTES) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        add_byte(8'($urandom_range(0, 127)), 1'b0);
      end else if (k < 80) begin
        n = (k < 50) ? 2 : (k < 65) ? 3 : 4;
        add_byte(lead_byte(n), 1'b0);
        for (int j = 1; j < n; j++) add_byte(cont_byte(), 1'b0);
      end else if (k < 90) begin
        n = $urandom_range(2, 4);
        add_byte(lead_byte(n), 1'b0);
        for (int j = 0; j < $urandom_range(0, n - 2); j++) add_byte(cont_byte(), 1'b0);
        if ($urandom_range(0, 1) == 1) text_bytes[text_bytes.size()-1].eot = 1'b1;
      end else begin
        add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 11) == 0) text_bytes[text_bytes.size()-1].eot = 1'b1;
    end
    text_bytes[text_bytes.size()-1].eot = 1'b1;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input text_item_t t, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= t.b;
    in_end_of_text <= t.eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int unsigned gap;
    int unsigned quiet;
    int k;
    quiet = 0;
    build_directed();
    directed_count = text_bytes.size();
    build_random();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < text_bytes.size(); i++) begin
      if (i == directed_count) begin
        hold_req = 1'b1;
        quiet = 60;
      end
      if (quiet > 0) begin
        gap = 0;
        quiet--;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 55) gap = 0;
        else if (k < 85) gap = $urandom_range(1, 3);
        else if (k < 95) begin
          gap = 0;
          quiet = $urandom_range(15, 40);
        end else gap = $urandom_range(10, 40);
      end
      send_item(text_bytes[i], gap);
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int k;
    int unsigned calm;
    calm = 0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        k = $urandom_range(0, 99);
        if (calm > 0) begin
          out_ready <= 1'b1;
          calm--;
        end else if (k < 70) begin
          out_ready <= 1'b1;
        end else if (k < 95) begin
          out_ready <= 1'b0;
        end else if (k < 97) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(8, 30)) @(negedge clk);
          continue;
        end else begin
          out_ready <= 1'b1;
          calm = $urandom_range(20, 60);
        end
        @(negedge clk);
      end
    end
  end

endmodule

>>> filelist.f
sv/utf8d_pkg.sv
sv/utf8d_decode.sv
sv/utf8d_emit.sv
sv/utf8_codepoint_decoder.sv
sim/utf8_codepoint_checker.sv
sim/utf8_codepoint_decoder_test.sv
